FILE: design/assert_macros.svh
// Assertion macros used by countdown_round_timer_controller.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked property, checked during reset as well.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

FILE: design/crtc_pkg.sv
// Types, codes and constants of the countdown round timer controller.
// No dependencies.
package crtc_pkg;

   // Operating modes, encoded as seen on the result mode field
   typedef enum logic [1:0] {
      MODE_WAIT  = 2'd0,
      MODE_COUNT = 2'd1,
      MODE_STOP  = 2'd2
   } mode_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_PRESET_ONE   = 3'd0,
      CSR_PRESET_TWO   = 3'd1,
      CSR_PRESET_THREE = 3'd2,
      CSR_PRESET_FOUR  = 3'd3,
      CSR_LAST_TICK    = 3'd4
   } csr_index_type;

   // Master key codes (exact values only)
   localparam logic [7:0] KEY_PRESET_ONE   = 8'd1;
   localparam logic [7:0] KEY_PRESET_TWO   = 8'd2;
   localparam logic [7:0] KEY_PRESET_THREE = 8'd4;
   localparam logic [7:0] KEY_PRESET_FOUR  = 8'd8;
   localparam logic [7:0] KEY_START        = 8'd16;
   localparam logic [7:0] KEY_RESET        = 8'd32;

   // Lamp bit positions
   localparam int LAMP_START  = 0;
   localparam int LAMP_FALSE  = 1;
   localparam int LAMP_PLAYER = 2;

   // Beep tone and length per event
   localparam logic [7:0] TONE_START  = 8'd200;
   localparam logic [7:0] LEN_START   = 8'd50;
   localparam logic [7:0] TONE_PLAYER = 8'd25;
   localparam logic [7:0] LEN_PLAYER  = 8'd100;
   localparam logic [7:0] TONE_FALSE  = 8'd150;
   localparam logic [7:0] LEN_FALSE   = 8'd200;
   localparam logic [7:0] TONE_END    = 8'd100;
   localparam logic [7:0] LEN_END     = 8'd100;

   // Register reset values
   localparam logic [6:0]  RST_PRESET_ONE   = 7'd60;
   localparam logic [6:0]  RST_PRESET_TWO   = 7'd30;
   localparam logic [6:0]  RST_PRESET_THREE = 7'd10;
   localparam logic [6:0]  RST_PRESET_FOUR  = 7'd5;
   localparam logic [15:0] RST_LAST_TICK    = 16'd99;

   // Seven-segment pattern gfedcba- of one decimal digit, blank above nine
   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      unique case (digit)
         4'd0: pat = 8'h7E;
         4'd1: pat = 8'h0C;
         4'd2: pat = 8'hB6;
         4'd3: pat = 8'h9E;
         4'd4: pat = 8'hCC;
         4'd5: pat = 8'hDA;
         4'd6: pat = 8'hFA;
         4'd7: pat = 8'h0E;
         4'd8: pat = 8'hFE;
         4'd9: pat = 8'hDE;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

endpackage

FILE: design/countdown_round_timer_controller.sv
// Countdown round timer controller: one request per clock, each a tick flag plus master and
// player key samples, answered by one result (segment patterns, lamps, beep, mode) in the cycle
// after acceptance. A request is taken every cycle while the result register is empty or
// being drained; the result comes from the single registered pass from the state registers
// through the key and tick logic into the result register. No clearing pass after reset.
// Depends on crtc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module countdown_round_timer_controller (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // tick[0], master_keys[8:1], player_keys[12:9], zero pad
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // tens_segments[7:0], ones_segments[15:8],
                                    // start_lamp[16], false_start_lamp[17],
                                    // player_lamps[21:18], beep_on[22],
                                    // tone_divider[30:23], mode[32:31], zero pad
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   // Request fields
   logic       tick;
   logic [7:0] master_keys;
   logic [3:0] player_keys;
   assign tick        = req_tdata[0];
   assign master_keys = req_tdata[8:1];
   assign player_keys = req_tdata[12:9];

   logic req_fire;
   logic rsp_valid_ff;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign csr_ready  = 1'b1;

   // Configuration registers
   logic [6:0]  preset_one_ff, preset_two_ff, preset_three_ff, preset_four_ff;
   logic [15:0] last_tick_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         preset_one_ff   <= crtc_pkg::RST_PRESET_ONE;
         preset_two_ff   <= crtc_pkg::RST_PRESET_TWO;
         preset_three_ff <= crtc_pkg::RST_PRESET_THREE;
         preset_four_ff  <= crtc_pkg::RST_PRESET_FOUR;
         last_tick_ff    <= crtc_pkg::RST_LAST_TICK;
      end else if (csr_valid) begin
         unique case (crtc_pkg::csr_index_type'(csr_index))
            crtc_pkg::CSR_PRESET_ONE:   preset_one_ff   <= csr_data[6:0];
            crtc_pkg::CSR_PRESET_TWO:   preset_two_ff   <= csr_data[6:0];
            crtc_pkg::CSR_PRESET_THREE: preset_three_ff <= csr_data[6:0];
            crtc_pkg::CSR_PRESET_FOUR:  preset_four_ff  <= csr_data[6:0];
            crtc_pkg::CSR_LAST_TICK:    last_tick_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Timer state
   crtc_pkg::mode_type mode_ff, mode_in;
   logic [6:0]  secs_ff, secs_in;
   logic [6:0]  restart_ff, restart_in;
   logic [6:0]  shown_ff, shown_in;
   logic [15:0] frac_ff, frac_in;
   logic        done_ff, done_in;
   logic [7:0]  beep_rem_ff, beep_rem_in;
   logic        beep_act_ff, beep_act_in;
   logic [7:0]  tone_ff, tone_in;
   logic [5:0]  lamps_ff, lamps_in;

   // Next state: tick first, then keys by mode
   always_comb begin
      logic ended;
      logic player_one_hot;
      mode_in     = mode_ff;
      secs_in     = secs_ff;
      restart_in  = restart_ff;
      shown_in    = shown_ff;
      frac_in     = frac_ff;
      done_in     = done_ff;
      beep_rem_in = beep_rem_ff;
      beep_act_in = beep_act_ff;
      tone_in     = tone_ff;
      lamps_in    = lamps_ff;
      player_one_hot = (player_keys == 4'd1) || (player_keys == 4'd2) ||
                       (player_keys == 4'd4) || (player_keys == 4'd8);

      // timer period: fraction and seconds, then beep length
      if (tick) begin
         if (!done_ff) begin
            if (secs_ff != 7'd0) begin
               if (frac_ff == last_tick_ff) begin
                  frac_in = 16'd0;
                  secs_in = secs_ff - 7'd1;
               end else begin
                  frac_in = frac_ff + 16'd1;
               end
            end else begin
               done_in = 1'b1;
            end
         end
         if (beep_rem_ff != 8'd0) begin
            beep_rem_in = beep_rem_ff - 8'd1;
         end else begin
            beep_act_in = 1'b0;
         end
      end

      ended = done_in;
      unique case (mode_ff)
         crtc_pkg::MODE_COUNT: begin
            if (master_keys == crtc_pkg::KEY_RESET) begin
               lamps_in = 6'd0;
               secs_in  = restart_ff;
               done_in  = 1'b1;
               mode_in  = crtc_pkg::MODE_WAIT;
            end
            // countdown already over: end beep and stop
            if (ended) begin
               tone_in     = crtc_pkg::TONE_END;
               beep_rem_in = crtc_pkg::LEN_END;
               beep_act_in = 1'b1;
               lamps_in[crtc_pkg::LAMP_START] = 1'b0;
               secs_in     = restart_ff;
               mode_in     = crtc_pkg::MODE_STOP;
            end
            shown_in = secs_in;
            // player press ends the round; lamp only for a single player
            if (player_one_hot) begin
               lamps_in[5:2] = lamps_in[5:2] | player_keys;
            end
            if (player_keys != 4'd0) begin
               done_in     = 1'b1;
               tone_in     = crtc_pkg::TONE_PLAYER;
               beep_rem_in = crtc_pkg::LEN_PLAYER;
               beep_act_in = 1'b1;
               mode_in     = crtc_pkg::MODE_STOP;
            end
         end
         crtc_pkg::MODE_STOP: begin
            if (master_keys == crtc_pkg::KEY_RESET) begin
               lamps_in = 6'd0;
               secs_in  = restart_ff;
               shown_in = restart_ff;
               done_in  = 1'b1;
               mode_in  = crtc_pkg::MODE_WAIT;
            end
         end
         default: begin
            // waiting (unused code three behaves the same)
            mode_in = crtc_pkg::MODE_WAIT;
            unique case (master_keys)
               crtc_pkg::KEY_PRESET_ONE:   secs_in = preset_one_ff;
               crtc_pkg::KEY_PRESET_TWO:   secs_in = preset_two_ff;
               crtc_pkg::KEY_PRESET_THREE: secs_in = preset_three_ff;
               crtc_pkg::KEY_PRESET_FOUR:  secs_in = preset_four_ff;
               default: ;
            endcase
            if (master_keys != 8'd0) begin
               shown_in = secs_in;
            end
            if (master_keys == crtc_pkg::KEY_START) begin
               lamps_in[crtc_pkg::LAMP_START] = 1'b1;
               tone_in     = crtc_pkg::TONE_START;
               beep_rem_in = crtc_pkg::LEN_START;
               beep_act_in = 1'b1;
               restart_in  = secs_in;
               frac_in     = 16'd0;
               done_in     = 1'b0;
               mode_in     = crtc_pkg::MODE_COUNT;
            end else if (player_keys != 4'd0) begin
               lamps_in[crtc_pkg::LAMP_FALSE] = 1'b1;
               tone_in     = crtc_pkg::TONE_FALSE;
               beep_rem_in = crtc_pkg::LEN_FALSE;
               beep_act_in = 1'b1;
               mode_in     = crtc_pkg::MODE_STOP;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= crtc_pkg::MODE_WAIT;
         secs_ff     <= crtc_pkg::RST_PRESET_ONE;
         restart_ff  <= crtc_pkg::RST_PRESET_ONE;
         shown_ff    <= crtc_pkg::RST_PRESET_ONE;
         frac_ff     <= 16'd0;
         done_ff     <= 1'b1;
         beep_rem_ff <= 8'd0;
         beep_act_ff <= 1'b0;
         tone_ff     <= 8'd0;
         lamps_ff    <= 6'd0;
      end else if (req_fire) begin
         mode_ff     <= mode_in;
         secs_ff     <= secs_in;
         restart_ff  <= restart_in;
         shown_ff    <= shown_in;
         frac_ff     <= frac_in;
         done_ff     <= done_in;
         beep_rem_ff <= beep_rem_in;
         beep_act_ff <= beep_act_in;
         tone_ff     <= tone_in;
         lamps_ff    <= lamps_in;
      end
   end

   // Decimal split of the shown value: tens = (v * 205) >> 11, exact below 1024
   logic [14:0] tens_prod;
   logic [3:0]  tens_digit, ones_digit;
   logic [6:0]  tens_times_ten;
   assign tens_prod      = {8'd0, shown_in} * 15'd205;
   assign tens_digit     = tens_prod[14:11];
   assign tens_times_ten = 7'(tens_digit) * 7'd10;
   assign ones_digit     = 4'(shown_in - tens_times_ten);

   // Result register
   logic [39:0] rsp_data_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= {7'd0, mode_in, tone_in, beep_act_in, lamps_in[5:2],
                         lamps_in[crtc_pkg::LAMP_FALSE], lamps_in[crtc_pkg::LAMP_START],
                         crtc_pkg::seg_pattern(ones_digit),
                         crtc_pkg::seg_pattern(tens_digit)};
      end
   end
   assign rsp_tdata = rsp_data_ff;

   // Checks
   `ASSERT_CLK_RST(a_req_gives_rsp, clock, reset, req_fire |=> rsp_valid_ff)
   `ASSERT_CLK_RST(a_count_lamp, clock, reset,
      (mode_ff == crtc_pkg::MODE_COUNT) |-> lamps_ff[crtc_pkg::LAMP_START])
   `ASSERT_CLK_RST(a_running_only_counting, clock, reset,
      !done_ff |-> (mode_ff == crtc_pkg::MODE_COUNT))
   `ASSERT_CLK(a_reset_empties, clock, reset |=> !rsp_valid_ff)

endmodule
